// ===== hw/rtl/ifs_pkg.sv =====
// shared types, constants and functions for the imu frame serializer
// no dependencies; used by ifs_crc16, ifs_serializer and the top level
package ifs_pkg;

  localparam int NUM_READINGS = 7;
  localparam int READING_W    = 16;
  localparam int STAMP_W      = 32;
  localparam int COUNT_W      = 32;
  localparam int SAMPLE_W     = STAMP_W + NUM_READINGS * READING_W;
  localparam int IDX_W        = 5;

  localparam logic [7:0]  SYNC_HI      = 8'hAA;
  localparam logic [7:0]  SYNC_LO      = 8'h55;
  localparam logic [7:0]  PAYLOAD_LEN  = 8'd18;
  localparam logic [7:0]  CORRUPT_MASK = 8'h01;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam int          INJECT_PERIOD = 10;

  // byte positions inside the 24-byte frame
  localparam logic [IDX_W-1:0] IDX_SYNC_HI  = 5'd0;
  localparam logic [IDX_W-1:0] IDX_SYNC_LO  = 5'd1;
  localparam logic [IDX_W-1:0] IDX_LEN      = 5'd2;
  localparam logic [IDX_W-1:0] IDX_SEQ      = 5'd3;
  localparam logic [IDX_W-1:0] IDX_STAMP    = 5'd4;
  localparam logic [IDX_W-1:0] IDX_READINGS = 5'd8;
  localparam logic [IDX_W-1:0] IDX_CORRUPT  = 5'd12;
  localparam logic [IDX_W-1:0] IDX_CRC_LAST = 5'd21;
  localparam logic [IDX_W-1:0] IDX_CRC_HI   = 5'd22;
  localparam logic [IDX_W-1:0] IDX_CRC_LO   = 5'd23;

  typedef struct packed {
    logic [COUNT_W-1:0]                     count;
    logic                                   corrupt;
    logic [7:0]                             seq;
    logic [NUM_READINGS-1:0][READING_W-1:0] readings;
    logic [STAMP_W-1:0]                     timestamp;
  } ifs_frame_t;

  typedef struct packed {
    logic       init;
    logic       update;
    logic [7:0] data;
  } ifs_crc_ctl_t;

  // one byte of crc-16/ccitt-false, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

  // compare against every multiple of ten that fits in a byte
  function automatic logic is_inject_seq(input logic [7:0] seq);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k * INJECT_PERIOD < 256; k++) begin
      if (seq == 8'(k * INJECT_PERIOD)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== hw/rtl/ifs_crc16.sv =====
// crc-16/ccitt-false accumulator, one byte per cycle while update is set
// depends on ifs_pkg
module ifs_crc16 (
  input  logic                clk,
  input  ifs_pkg::ifs_crc_ctl_t ctl,
  output logic [15:0]         crc
);
  import ifs_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      crc <= CRC_INIT;
    end else if (ctl.update) begin
      crc <= crc16_byte(crc, ctl.data);
    end
  end

endmodule

// ===== hw/rtl/ifs_serializer.sv =====
// frame register, byte index and output register of the frame stream
// depends on ifs_pkg and ifs_crc16
module ifs_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  input  ifs_pkg::ifs_frame_t frame_in,
  output logic                take,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,   // [7:0] frame_byte, [39:8] injected_count
  output logic                m_axis_tlast    // end_of_frame
);
  import ifs_pkg::*;

  logic             busy;
  logic [IDX_W-1:0] idx;
  ifs_frame_t       frame;
  logic             out_free;
  logic [7:0]       raw_byte;
  logic [7:0]       tx_byte;
  logic [15:0]      crc;
  logic [IDX_W-1:0] rel;
  logic [2:0]       ri;
  logic [1:0]       si;
  ifs_crc_ctl_t     crc_ctl;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign take     = out_free && sample_valid && (!busy || idx == IDX_CRC_LO);

  assign rel = idx - IDX_READINGS;
  assign ri  = rel[3:1];
  assign si  = idx[1:0];

  // uncorrupted frame byte at the current index
  always_comb begin
    if (idx == IDX_SYNC_HI) begin
      raw_byte = SYNC_HI;
    end else if (idx == IDX_SYNC_LO) begin
      raw_byte = SYNC_LO;
    end else if (idx == IDX_LEN) begin
      raw_byte = PAYLOAD_LEN;
    end else if (idx == IDX_SEQ) begin
      raw_byte = frame.seq;
    end else if (idx < IDX_READINGS) begin
      raw_byte = frame.timestamp[si*8 +: 8];
    end else if (idx <= IDX_CRC_LAST) begin
      raw_byte = rel[0] ? frame.readings[ri][7:0] : frame.readings[ri][15:8];
    end else if (idx == IDX_CRC_HI) begin
      raw_byte = crc[15:8];
    end else begin
      raw_byte = crc[7:0];
    end
  end

  assign tx_byte = (frame.corrupt && idx == IDX_CORRUPT) ? (raw_byte ^ CORRUPT_MASK) : raw_byte;

  always_comb begin
    crc_ctl.init   = take;
    crc_ctl.update = out_free && busy && idx >= IDX_LEN && idx <= IDX_CRC_LAST;
    crc_ctl.data   = raw_byte;
  end

  ifs_crc16 u_crc (
    .clk (clk),
    .ctl (crc_ctl),
    .crc (crc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      idx           <= IDX_SYNC_HI;
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= busy;
      if (take) begin
        busy <= 1'b1;
        idx  <= IDX_SYNC_HI;
      end else if (busy) begin
        if (idx == IDX_CRC_LO) begin
          busy <= 1'b0;
          idx  <= IDX_SYNC_HI;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame <= frame_in;
    end
    if (out_free && busy) begin
      m_axis_tdata <= {frame.count, tx_byte};
      m_axis_tlast <= (idx == IDX_CRC_LO);
    end
  end

`ifndef SYNTHESIS
  a_mid_frame_valid: assert property (@(posedge clk) disable iff (rst)
    busy && idx != IDX_SYNC_HI |-> m_axis_tvalid)
    else $error("frame in progress without a pending output byte");

  a_start_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> idx == IDX_SYNC_HI)
    else $error("frame started at a nonzero byte index");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a frame");
`endif

endmodule

// ===== hw/rtl/imu_frame_serializer_crc16.sv =====
// top level of the imu frame serializer: sample buffer, sequence and
// injection state, configuration register; depends on ifs_pkg, ifs_serializer
// (which holds ifs_crc16)
//
// One sample transaction in, one 24-byte frame out, one byte per transaction
// on the master side with tlast on the final byte. Frame layout: AA 55, length
// 18, sequence number, timestamp little-endian, the seven readings big-endian,
// then crc-16/ccitt-false (init FFFF, poly 1021) over bytes 2..21, high byte
// first. With inject_errors set, every frame whose incremented sequence number
// is a multiple of ten goes out with bit 0 of byte 12 flipped (crc left as for
// the clean frame) and the saturating injected_count steps by one; every byte
// of a frame carries the count after that frame's update. Frames leave through
// the single byte-wide output register; the crc is built one byte per cycle as
// the frame is sent, unless the master side stalls. A one-entry sample buffer
// takes the next sample while the current frame streams, so back-to-back
// frames follow without a gap. From idle, the frame register and then the
// output register are loaded. Write inject_errors only while idle.
module imu_frame_serializer_crc16 (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [31:0] timestamp_us, [47:32] accel_x, [63:48] accel_y, [79:64] accel_z,
  // [95:80] temperature, [111:96] gyro_x, [127:112] gyro_y, [143:128] gyro_z
  input  logic [143:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [39:0]   m_axis_tdata,   // [7:0] frame_byte, [39:8] injected_count
  output logic          m_axis_tlast,   // end_of_frame
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data        // inject_errors
);
  import ifs_pkg::*;

  // one-entry sample buffer
  logic                sample_valid;
  logic [SAMPLE_W-1:0] sample_data;
  logic                take;

  // persistent frame state
  logic [7:0]          sequence_number;
  logic [COUNT_W-1:0]  corrupted_frames;
  logic                inject_errors;

  logic [7:0]          seq_next;
  logic                corrupt;
  logic [COUNT_W-1:0]  corrupted_frames_next;
  ifs_frame_t          frame_in;

  assign s_axis_tready = !sample_valid;
  assign cfg_ready     = 1'b1;

  // sequence and injection decision for the frame being loaded
  assign seq_next = sequence_number + 8'd1;
  assign corrupt  = inject_errors && is_inject_seq(seq_next);

  always_comb begin
    corrupted_frames_next = corrupted_frames;
    if (corrupt && corrupted_frames != '1) begin
      corrupted_frames_next = corrupted_frames + 1'b1;
    end
  end

  always_comb begin
    frame_in.timestamp = sample_data[STAMP_W-1:0];
    frame_in.readings  = sample_data[SAMPLE_W-1:STAMP_W];
    frame_in.seq       = sequence_number;
    frame_in.corrupt   = corrupt;
    frame_in.count     = corrupted_frames_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid     <= 1'b0;
      sequence_number  <= 8'd0;
      corrupted_frames <= '0;
      inject_errors    <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sample_valid <= 1'b1;
      end else if (take) begin
        sample_valid <= 1'b0;
      end
      if (take) begin
        sequence_number  <= seq_next;
        corrupted_frames <= corrupted_frames_next;
      end
      if (cfg_valid && cfg_ready) begin
        inject_errors <= cfg_data;
      end
    end
  end

  // sample payload needs no reset
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_data <= s_axis_tdata;
    end
  end

  ifs_serializer u_serializer (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .frame_in      (frame_in),
    .take          (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
